[rtl/mfmc_pkg.sv]
// Package with constants, payload types and controller states of the min cut solver.
`timescale 1ns / 1ps
package mfmc_pkg;

  localparam int unsigned MAX_NODES = 32;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned MAX_EDGES = 1024;
  localparam int unsigned EDGE_AW   = $clog2(MAX_EDGES);
  localparam int unsigned CNT_W     = EDGE_AW + 1;
  localparam int unsigned CAP_BITS  = 24;
  localparam int unsigned FLOW_W    = 48;
  localparam int unsigned RES_AW    = 2 * NODE_W;
  localparam int unsigned RES_DEPTH = MAX_NODES * MAX_NODES;
  localparam int unsigned FIELD_W   = 6;
  localparam int unsigned CUTCAP_W  = 34;
  localparam int unsigned POS_W     = 10;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [FIELD_W-1:0]  from_node;
    logic [FIELD_W-1:0]  to_node;
    logic [CAP_BITS-1:0] capacity;
    logic                last_edge;
    logic [POS_W-1:0]    cut_position;
  } mfmc_in_t;

  typedef struct packed {
    logic [CUTCAP_W-1:0] cut_capacity;
    logic [CNT_W-1:0]    cut_size;
    logic [CNT_W-1:0]    cut_edge_number;
    logic                position_invalid;
  } mfmc_out_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  tail;
    logic [FIELD_W-1:0]  head;
    logic [CAP_BITS-1:0] cap;
  } mfmc_edge_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_CLR,
    ST_LD_RD,
    ST_LD_MUL,
    ST_LD_WR,
    ST_BFS_INIT,
    ST_BFS_POP,
    ST_SCAN,
    ST_MIN,
    ST_UPD_A,
    ST_UPD_B,
    ST_UPD_C,
    ST_DIV,
    ST_TRY_RD,
    ST_TRY_MUL,
    ST_TRY_CMP,
    ST_DONE
  } mfmc_state_e;

endpackage

[rtl/mfmc_intf.sv]
// Handshake channel interfaces for the min cut solver: items, results and configuration.
`timescale 1ns / 1ps
interface mfmc_in_if;
  import mfmc_pkg::*;
  logic     valid;
  logic     ready;
  mfmc_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfmc_out_if;
  import mfmc_pkg::*;
  logic      valid;
  logic      ready;
  mfmc_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfmc_cfg_if;
  import mfmc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/max_flow_min_cut_edges_top.sv]
// Top level of the fewest-edge minimum cut solver built around a residual matrix memory.
`timescale 1ns / 1ps
// Edge loads are taken one beat per cycle while the solver is idle; a cut read passes through
// the read state, waiting for a free result slot, before its result is registered. A beat with
// last_edge set starts the solve, and input stalls until the result is emitted: each flow run
// clears the residual matrix, loads every stored edge, and runs path searches, each followed by
// a bottleneck walk and an augment, with one initial run, a divider and one run per edge on top.
// Reset (asynchronous, active low) empties the edge store and cut list and sets 32 nodes.
module max_flow_min_cut_edges_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  mfmc_in_if.sink     in_i,
  mfmc_out_if.source  out_o,
  mfmc_cfg_if.sink    cfg_i
);
  import mfmc_pkg::*;

  // Storage: edge list, ban flags, residual matrix and the cut list are all memories.
  mfmc_edge_t           edge_mem [MAX_EDGES];
  logic                 banned_mem [MAX_EDGES];
  logic [FLOW_W-1:0]    res_mem [RES_DEPTH];
  logic [CNT_W-1:0]     cut_mem [MAX_EDGES];

  mfmc_edge_t           edge_rd_q;
  logic                 banned_rd_q;
  logic [FLOW_W-1:0]    res_rd_q;
  logic [CNT_W-1:0]     cut_rd_q;

  logic                 edge_we;
  logic [EDGE_AW-1:0]   edge_wa, edge_ra;
  mfmc_edge_t           edge_wd;
  logic                 banned_we, banned_wd;
  logic [EDGE_AW-1:0]   banned_wa;
  logic                 res_we;
  logic [RES_AW-1:0]    res_wa, res_ra;
  logic [FLOW_W-1:0]    res_wd;
  logic                 cut_we;
  logic [EDGE_AW-1:0]   cut_wa, cut_ra;
  logic [CNT_W-1:0]     cut_wd;

  // Controller state.
  mfmc_state_e          state_q, state_d;
  logic [FIELD_W-1:0]   nodes_q, nodes_d;
  logic [CNT_W-1:0]     edge_total_q, edge_total_d;
  logic [CNT_W-1:0]     cut_count_q, cut_count_d;
  logic [CUTCAP_W-1:0]  cut_value_q, cut_value_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     try_q, try_d;
  logic                 trying_q, trying_d;
  logic [RES_AW-1:0]    clr_q, clr_d;
  logic [FLOW_W-1:0]    best_q, best_d;
  logic [FLOW_W-1:0]    flow_q, flow_d;
  logic [FLOW_W-1:0]    push_q, push_d;
  logic [FLOW_W-1:0]    prod_q, prod_d;
  logic                 ld_ok_q, ld_ok_d;
  logic [RES_AW-1:0]    ld_addr_q, ld_addr_d;
  logic [MAX_NODES-1:0] visited_q, visited_d;
  logic [NODE_W-1:0]    came_q [MAX_NODES];
  logic [NODE_W-1:0]    queue_q [MAX_NODES];
  logic                 came_we, queue_we;
  logic [NODE_W-1:0]    came_wa, came_wd, queue_wa, queue_wd;
  logic [NODE_W:0]      qhead_q, qhead_d, qtail_q, qtail_d;
  logic [NODE_W-1:0]    x_q, x_d;
  logic [NODE_W:0]      y_q, y_d;
  logic                 pend_q, pend_d;
  logic [NODE_W-1:0]    pend_y_q, pend_y_d;
  logic [NODE_W-1:0]    walk_q, walk_d;
  logic [FLOW_W-1:0]    div_n_q, div_n_d;
  logic [CNT_W-1:0]     div_r_q, div_r_d;
  logic [5:0]           div_cnt_q, div_cnt_d;
  logic [POS_W-1:0]     rd_pos_q, rd_pos_d;
  logic                 out_valid_q, out_valid_d;
  mfmc_out_t            out_q, out_d;

  // Derived values.
  logic [FIELD_W-1:0]   nodes_eff;
  logic [NODE_W-1:0]    sink;
  logic [CNT_W-1:0]     scale;
  logic                 slot_free;
  logic                 in_acc;
  logic [CNT_W:0]       div_r2;
  logic [FLOW_W-1:0]    weight;
  logic [NODE_W-1:0]    walk_from;

  always_comb begin
    if (nodes_q < FIELD_W'(2)) begin
      nodes_eff = FIELD_W'(2);
    end else if (nodes_q > FIELD_W'(MAX_NODES)) begin
      nodes_eff = FIELD_W'(MAX_NODES);
    end else begin
      nodes_eff = nodes_q;
    end
  end

  assign sink      = NODE_W'(nodes_eff - FIELD_W'(1));
  assign scale     = edge_total_q + CNT_W'(1);
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc    = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign div_r2    = {div_r_q, div_n_q[FLOW_W-1]};
  assign weight    = prod_q + FLOW_W'(1);
  assign walk_from = came_q[walk_q];

  // Next state and datapath control. Every residual update is a read in one state and a
  // write in a later one, so no two accesses to the same entry overlap.
  always_comb begin
    state_d      = state_q;
    nodes_d      = nodes_q;
    edge_total_d = edge_total_q;
    cut_count_d  = cut_count_q;
    cut_value_d  = cut_value_q;
    idx_d        = idx_q;
    try_d        = try_q;
    trying_d     = trying_q;
    clr_d        = clr_q;
    best_d       = best_q;
    flow_d       = flow_q;
    push_d       = push_q;
    prod_d       = prod_q;
    ld_ok_d      = ld_ok_q;
    ld_addr_d    = ld_addr_q;
    visited_d    = visited_q;
    qhead_d      = qhead_q;
    qtail_d      = qtail_q;
    x_d          = x_q;
    y_d          = y_q;
    pend_d       = 1'b0;
    pend_y_d     = pend_y_q;
    walk_d       = walk_q;
    div_n_d      = div_n_q;
    div_r_d      = div_r_q;
    div_cnt_d    = div_cnt_q;
    rd_pos_d     = rd_pos_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;

    edge_we   = 1'b0;
    edge_wa   = edge_total_q[EDGE_AW-1:0];
    edge_wd   = '{tail: in_i.data.from_node, head: in_i.data.to_node,
                  cap: in_i.data.capacity};
    edge_ra   = idx_q[EDGE_AW-1:0];
    banned_we = 1'b0;
    banned_wa = edge_total_q[EDGE_AW-1:0];
    banned_wd = 1'b0;
    res_we    = 1'b0;
    res_wa    = clr_q;
    res_wd    = '0;
    res_ra    = {x_q, y_q[NODE_W-1:0]};
    cut_we    = 1'b0;
    cut_wa    = cut_count_q[EDGE_AW-1:0];
    cut_wd    = try_q + CNT_W'(1);
    cut_ra    = in_i.data.cut_position;
    came_we   = 1'b0;
    came_wa   = pend_y_q;
    came_wd   = x_q;
    queue_we  = 1'b0;
    queue_wa  = qtail_q[NODE_W-1:0];
    queue_wd  = pend_y_q;

    if (cfg_i.valid && cfg_i.ready) begin
      nodes_d = cfg_i.data;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.data.kind == KIND_READ) begin
            rd_pos_d = in_i.data.cut_position;
            state_d  = ST_READ;
          end else begin
            if (edge_total_q < CNT_W'(MAX_EDGES)) begin
              edge_we      = 1'b1;
              banned_we    = 1'b1;
              edge_total_d = edge_total_q + CNT_W'(1);
            end
            if (in_i.data.last_edge) begin
              cut_count_d = '0;
              trying_d    = 1'b0;
              clr_d       = '0;
              flow_d      = '0;
              state_d     = ST_CLR;
            end
          end
        end
      end
      ST_READ: begin
        // Keep the stored position on the cut list address while the result waits.
        cut_ra = rd_pos_q;
        if (slot_free) begin
          out_valid_d               = 1'b1;
          out_d.cut_capacity        = cut_value_q;
          out_d.cut_size            = cut_count_q;
          if ({1'b0, rd_pos_q} < cut_count_q) begin
            out_d.cut_edge_number  = cut_rd_q;
            out_d.position_invalid = 1'b0;
          end else begin
            out_d.cut_edge_number  = '0;
            out_d.position_invalid = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      ST_CLR: begin
        res_we = 1'b1;
        clr_d  = clr_q + RES_AW'(1);
        if (clr_q == RES_AW'(RES_DEPTH - 1)) begin
          idx_d   = '0;
          state_d = (edge_total_q == '0) ? ST_BFS_INIT : ST_LD_RD;
        end
      end
      ST_LD_RD: begin
        state_d = ST_LD_MUL;
      end
      ST_LD_MUL: begin
        ld_ok_d = !banned_rd_q && !(trying_q && idx_q == try_q)
                  && edge_rd_q.tail != '0 && edge_rd_q.tail <= nodes_eff
                  && edge_rd_q.head != '0 && edge_rd_q.head <= nodes_eff;
        ld_addr_d = {NODE_W'(edge_rd_q.tail - FIELD_W'(1)),
                     NODE_W'(edge_rd_q.head - FIELD_W'(1))};
        res_ra  = ld_addr_d;
        prod_d  = FLOW_W'(edge_rd_q.cap * scale);
        state_d = ST_LD_WR;
      end
      ST_LD_WR: begin
        if (ld_ok_q) begin
          res_we = 1'b1;
          res_wa = ld_addr_q;
          res_wd = res_rd_q + prod_q + FLOW_W'(1);
        end
        idx_d = idx_q + CNT_W'(1);
        state_d = (idx_d == edge_total_q) ? ST_BFS_INIT : ST_LD_RD;
      end
      ST_BFS_INIT: begin
        visited_d = MAX_NODES'(1);
        queue_we  = 1'b1;
        queue_wa  = '0;
        queue_wd  = '0;
        qhead_d   = '0;
        qtail_d   = (NODE_W + 1)'(1);
        state_d   = ST_BFS_POP;
      end
      ST_BFS_POP: begin
        if (visited_q[sink]) begin
          walk_d  = sink;
          push_d  = '1;
          state_d = ST_MIN;
        end else if (qhead_q < qtail_q) begin
          x_d     = queue_q[qhead_q[NODE_W-1:0]];
          qhead_d = qhead_q + (NODE_W + 1)'(1);
          y_d     = '0;
          state_d = ST_SCAN;
        end else if (!trying_q) begin
          best_d    = flow_q;
          div_n_d   = flow_q;
          div_r_d   = '0;
          div_cnt_d = '0;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_TRY_RD;
        end
      end
      ST_SCAN: begin
        // One residual entry of row x is read per cycle; its answer is handled in the next cycle.
        if ({1'b0, y_q} < {1'b0, nodes_eff}) begin
          res_ra   = {x_q, y_q[NODE_W-1:0]};
          pend_d   = 1'b1;
          pend_y_d = y_q[NODE_W-1:0];
          y_d      = y_q + (NODE_W + 1)'(1);
        end
        if (pend_q && res_rd_q != '0 && !visited_q[pend_y_q]) begin
          visited_d[pend_y_q] = 1'b1;
          came_we  = 1'b1;
          queue_we = 1'b1;
          qtail_d  = qtail_q + (NODE_W + 1)'(1);
        end
        if (!pend_d && !pend_q) begin
          state_d = ST_BFS_POP;
        end
      end
      ST_MIN: begin
        if (walk_q != '0) begin
          res_ra = {walk_from, walk_q};
          pend_d = 1'b1;
          walk_d = walk_from;
        end
        if (pend_q && res_rd_q < push_q) begin
          push_d = res_rd_q;
        end
        if (!pend_d && !pend_q) begin
          walk_d  = sink;
          state_d = ST_UPD_A;
        end
      end
      ST_UPD_A: begin
        res_ra  = {walk_from, walk_q};
        state_d = ST_UPD_B;
      end
      ST_UPD_B: begin
        res_we  = 1'b1;
        res_wa  = {walk_from, walk_q};
        res_wd  = res_rd_q - push_q;
        res_ra  = {walk_q, walk_from};
        state_d = ST_UPD_C;
      end
      ST_UPD_C: begin
        res_we = 1'b1;
        res_wa = {walk_q, walk_from};
        res_wd = res_rd_q + push_q;
        walk_d = walk_from;
        if (walk_from == '0) begin
          flow_d  = flow_q + push_q;
          state_d = ST_BFS_INIT;
        end else begin
          state_d = ST_UPD_A;
        end
      end
      ST_DIV: begin
        // Restoring division of the first flow by the weight scale, one quotient bit a cycle.
        if (div_r2 >= {1'b0, scale}) begin
          div_r_d = CNT_W'(div_r2 - {1'b0, scale});
          div_n_d = {div_n_q[FLOW_W-2:0], 1'b1};
        end else begin
          div_r_d = div_r2[CNT_W-1:0];
          div_n_d = {div_n_q[FLOW_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + 6'd1;
        if (div_cnt_q == 6'(FLOW_W - 1)) begin
          cut_value_d = div_n_d[CUTCAP_W-1:0];
          try_d       = '0;
          trying_d    = 1'b1;
          clr_d       = '0;
          flow_d      = '0;
          state_d     = (edge_total_q == '0) ? ST_DONE : ST_CLR;
        end
      end
      ST_TRY_RD: begin
        edge_ra = try_q[EDGE_AW-1:0];
        state_d = ST_TRY_MUL;
      end
      ST_TRY_MUL: begin
        prod_d  = FLOW_W'(edge_rd_q.cap * scale);
        state_d = ST_TRY_CMP;
      end
      ST_TRY_CMP: begin
        // The edge stays in the cut only if banning it lowers the flow by its own weight.
        if (weight <= best_q && flow_q == best_q - weight) begin
          best_d      = best_q - weight;
          cut_we      = 1'b1;
          cut_count_d = cut_count_q + CNT_W'(1);
          banned_we   = 1'b1;
          banned_wa   = try_q[EDGE_AW-1:0];
          banned_wd   = 1'b1;
        end
        try_d  = try_q + CNT_W'(1);
        clr_d  = '0;
        flow_d = '0;
        state_d = (try_d == edge_total_q) ? ST_DONE : ST_CLR;
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d            = 1'b1;
          out_d.cut_capacity     = cut_value_q;
          out_d.cut_size         = cut_count_q;
          out_d.cut_edge_number  = '0;
          out_d.position_invalid = 1'b0;
          edge_total_d           = '0;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_wa] <= edge_wd;
    end
    edge_rd_q <= edge_mem[edge_ra];
  end

  always_ff @(posedge clk_i) begin
    if (banned_we) begin
      banned_mem[banned_wa] <= banned_wd;
    end
    banned_rd_q <= banned_mem[edge_ra];
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[res_wa] <= res_wd;
    end
    res_rd_q <= res_mem[res_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cut_we) begin
      cut_mem[cut_wa] <= cut_wd;
    end
    cut_rd_q <= cut_mem[cut_ra];
  end

  // Search bookkeeping: parent links and the node queue.
  always_ff @(posedge clk_i) begin
    if (came_we) begin
      came_q[came_wa] <= came_wd;
    end
    if (queue_we) begin
      queue_q[queue_wa] <= queue_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q      <= FIELD_W'(MAX_NODES);
      edge_total_q <= '0;
      cut_count_q  <= '0;
      cut_value_q  <= '0;
      idx_q        <= '0;
      try_q        <= '0;
      trying_q     <= 1'b0;
      clr_q        <= '0;
      visited_q    <= '0;
      qhead_q      <= '0;
      qtail_q      <= '0;
      y_q          <= '0;
      pend_q       <= 1'b0;
      div_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      push_q       <= '1;
    end else begin
      nodes_q      <= nodes_d;
      edge_total_q <= edge_total_d;
      cut_count_q  <= cut_count_d;
      cut_value_q  <= cut_value_d;
      idx_q        <= idx_d;
      try_q        <= try_d;
      trying_q     <= trying_d;
      clr_q        <= clr_d;
      visited_q    <= visited_d;
      qhead_q      <= qhead_d;
      qtail_q      <= qtail_d;
      y_q          <= y_d;
      pend_q       <= pend_d;
      div_cnt_q    <= div_cnt_d;
      out_valid_q  <= out_valid_d;
      push_q       <= push_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q    <= best_d;
    flow_q    <= flow_d;
    prod_q    <= prod_d;
    ld_ok_q   <= ld_ok_d;
    ld_addr_q <= ld_addr_d;
    x_q       <= x_d;
    pend_y_q  <= pend_y_d;
    walk_q    <= walk_d;
    div_n_q   <= div_n_d;
    div_r_q   <= div_r_d;
    rd_pos_q  <= rd_pos_d;
    out_q     <= out_d;
  end

  // Every queued node is marked visited and every visited node was queued.
  a_queue_matches_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BFS_POP || state_q == ST_SCAN) |-> $countones(visited_q) == qtail_q)
    else $error("queue length and visited set disagree");

  // While a search runs, the queue never holds more nodes than the graph has.
  a_queue_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BFS_POP || state_q == ST_SCAN) |-> qtail_q <= {1'b0, nodes_eff})
    else $error("queue overran the node count");

  // An augmenting path found by the search always carries positive flow.
  a_push_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD_A) |-> push_q != '0)
    else $error("augmenting with zero bottleneck");

  // The cut can hold at most one entry per edge already examined.
  a_cut_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRY_CMP) |-> cut_count_q <= try_q)
    else $error("cut list longer than edges examined");

  // A result is only raised from the read or finishing states.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_READ || $past(state_q) == ST_DONE))
    else $error("result raised outside read or finish");

endmodule

[test/mfmc_cut_checker.sv]
// Scoreboard that predicts and checks every result beat of the min cut solver.
`timescale 1ns / 1ps
module mfmc_cut_checker (
  input  logic clk_i,
  mfmc_in_if   in_mon,
  mfmc_out_if  out_mon,
  mfmc_cfg_if  cfg_mon,
  output int   errors_o,
  output int   pending_o
);
  import mfmc_pkg::*;

  // Mirror of the solver state.
  int unsigned     node_setting = 32;
  int unsigned     edge_from [MAX_EDGES];
  int unsigned     edge_to   [MAX_EDGES];
  bit [63:0]       edge_weight_cap [MAX_EDGES];
  bit              edge_off  [MAX_EDGES];
  int unsigned     edges_held = 0;
  int unsigned     cut_edges [MAX_EDGES];
  int unsigned     cut_edges_held = 0;
  bit [63:0]       cut_total = 0;
  bit [63:0]       res [MAX_NODES][MAX_NODES];

  mfmc_out_t cut_replies_q[$];

  initial begin
    errors_o = 0;
  end

  assign pending_o = cut_replies_q.size();

  function automatic void fill_residual(int unsigned nodes, bit [63:0] scale);
    int unsigned t, h;
    for (int x = 0; x < MAX_NODES; x++)
      for (int y = 0; y < MAX_NODES; y++)
        res[x][y] = '0;
    for (int i = 0; i < edges_held; i++) begin
      t = edge_from[i];
      h = edge_to[i];
      if (edge_off[i] || t < 1 || t > nodes || h < 1 || h > nodes) continue;
      res[t-1][h-1] += edge_weight_cap[i] * scale + 1;
    end
  endfunction

  // Breadth-first augmenting paths on the residual matrix until the sink is cut off.
  function automatic bit [63:0] augment_all(int unsigned nodes);
    bit          seen [MAX_NODES];
    int unsigned parent [MAX_NODES];
    int unsigned queue_n [MAX_NODES];
    int unsigned qh, qt, x, y;
    bit [63:0]   push, total;
    total = '0;
    while (1) begin
      for (int k = 0; k < MAX_NODES; k++) seen[k] = 1'b0;
      seen[0] = 1'b1;
      queue_n[0] = 0;
      qh = 0;
      qt = 1;
      while (qh < qt && !seen[nodes-1]) begin
        x = queue_n[qh];
        qh++;
        for (y = 0; y < nodes; y++) begin
          if (res[x][y] != 0 && !seen[y]) begin
            seen[y] = 1'b1;
            parent[y] = x;
            queue_n[qt] = y;
            qt++;
          end
        end
      end
      if (!seen[nodes-1]) break;
      push = {1'b0, {63{1'b1}}};
      for (y = nodes - 1; y != 0; y = parent[y])
        if (res[parent[y]][y] < push) push = res[parent[y]][y];
      for (y = nodes - 1; y != 0; y = parent[y]) begin
        res[parent[y]][y] -= push;
        res[y][parent[y]] += push;
      end
      total += push;
    end
    return total;
  endfunction

  function automatic void solve_min_cut();
    int unsigned nodes;
    bit [63:0]   scale, best, weight, flow;
    nodes = node_setting;
    if (nodes < 2) nodes = 2;
    if (nodes > MAX_NODES) nodes = MAX_NODES;
    scale = edges_held + 1;
    for (int i = 0; i < MAX_EDGES; i++) edge_off[i] = 1'b0;
    cut_edges_held = 0;
    fill_residual(nodes, scale);
    best = augment_all(nodes);
    cut_total = best / scale;
    for (int i = 0; i < edges_held; i++) begin
      weight = edge_weight_cap[i] * scale + 1;
      edge_off[i] = 1'b1;
      fill_residual(nodes, scale);
      flow = augment_all(nodes);
      if (weight <= best && flow == best - weight) begin
        best -= weight;
        cut_edges[cut_edges_held] = i + 1;
        cut_edges_held++;
      end else begin
        edge_off[i] = 1'b0;
      end
    end
    for (int i = 0; i < MAX_EDGES; i++) edge_off[i] = 1'b0;
    edges_held = 0;
  endfunction

  function automatic void predict_beat(mfmc_in_t it);
    mfmc_out_t r;
    r.cut_edge_number  = '0;
    r.position_invalid = 1'b0;
    if (it.kind == KIND_LOAD) begin
      if (edges_held < MAX_EDGES) begin
        edge_from[edges_held]       = it.from_node;
        edge_to[edges_held]         = it.to_node;
        edge_weight_cap[edges_held] = it.capacity;
        edges_held++;
      end
      if (!it.last_edge) return;
      solve_min_cut();
    end else if (it.cut_position < cut_edges_held) begin
      r.cut_edge_number = CNT_W'(cut_edges[it.cut_position]);
    end else begin
      r.position_invalid = 1'b1;
    end
    r.cut_capacity = cut_total[CUTCAP_W-1:0];
    r.cut_size     = CNT_W'(cut_edges_held);
    cut_replies_q.insert(cut_replies_q.size(), r);
  endfunction

  always @(posedge clk_i) begin
    if (cfg_mon.valid && cfg_mon.ready)
      node_setting = cfg_mon.data;
    if (in_mon.valid && in_mon.ready)
      predict_beat(in_mon.data);
  end

  always @(posedge clk_i) begin
    mfmc_out_t exp_r, act_r;
    if (out_mon.valid && out_mon.ready) begin
      act_r = out_mon.data;
      if (cut_replies_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, act_r);
        errors_o++;
      end else begin
        exp_r = cut_replies_q.pop_front();
        if (act_r.cut_capacity !== exp_r.cut_capacity) begin
          $display("%0t: cut_capacity expected %0d actual %0d", $time,
                   exp_r.cut_capacity, act_r.cut_capacity);
          errors_o++;
        end
        if (act_r.cut_size !== exp_r.cut_size) begin
          $display("%0t: cut_size expected %0d actual %0d", $time,
                   exp_r.cut_size, act_r.cut_size);
          errors_o++;
        end
        if (act_r.cut_edge_number !== exp_r.cut_edge_number) begin
          $display("%0t: cut_edge_number expected %0d actual %0d", $time,
                   exp_r.cut_edge_number, act_r.cut_edge_number);
          errors_o++;
        end
        if (act_r.position_invalid !== exp_r.position_invalid) begin
          $display("%0t: position_invalid expected %0d actual %0d", $time,
                   exp_r.position_invalid, act_r.position_invalid);
          errors_o++;
        end
      end
    end
  end

endmodule

[test/tb_max_flow_min_cut_edges_top.sv]
// Stimulus and verdict for the min cut solver; checking lives in the scoreboard beside it.
`timescale 1ns / 1ps
module tb_max_flow_min_cut_edges_top;
  import mfmc_pkg::*;

  // The slowest solve (a full edge store) accepts nothing until it finishes, so the
  // quiet-cycle limit is set with ample room above the length of that solve.
  localparam int QUIET_LIMIT = 25_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 700;
  localparam int IN_W = $bits(mfmc_in_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mfmc_in_if  in_if ();
  mfmc_out_if out_if ();
  mfmc_cfg_if cfg_if ();

  int errors, pending;
  int random_sent = 0;

  // When set, neither side inserts idle cycles; toggled per graph so that some
  // stretches run flat out.
  bit flat_out = 1'b0;
  // Asks the result side for one long hold-off; cleared by that process.
  bit hold_out = 1'b0;
  // Last value written to the node count register, for making sensible node numbers.
  int unsigned node_cfg = 32;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  max_flow_min_cut_edges_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  mfmc_cut_checker scoreboard (
    .clk_i     (clk_i),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .cfg_mon   (cfg_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  function automatic int draw_gap();
    return flat_out ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic int unsigned live_nodes();
    if (node_cfg < 2) return 2;
    if (node_cfg > MAX_NODES) return MAX_NODES;
    return node_cfg;
  endfunction

  // Every field not used by the beat carries random bits so that all bits toggle.
  function automatic mfmc_in_t edge_beat(int unsigned tail, int unsigned head,
                                         int unsigned cap, bit last);
    mfmc_in_t it;
    it              = mfmc_in_t'(IN_W'({$urandom, $urandom}));
    it.kind         = KIND_LOAD;
    it.from_node    = FIELD_W'(tail);
    it.to_node      = FIELD_W'(head);
    it.capacity     = CAP_BITS'(cap);
    it.last_edge    = last;
    return it;
  endfunction

  function automatic mfmc_in_t read_beat(int unsigned pos);
    mfmc_in_t it;
    it              = mfmc_in_t'(IN_W'({$urandom, $urandom}));
    it.kind         = KIND_READ;
    it.cut_position = POS_W'(pos);
    return it;
  endfunction

  // Inputs are changed at the falling edge; the beat is taken at the first rising
  // edge that sees ready high.
  task automatic send_beat(mfmc_in_t it);
    int gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.data  <= it;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // The register is only written once the solver has gone quiet: every result has
  // been returned, and a few spare cycles cover loads that produce no result.
  task automatic write_node_count(int unsigned value);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.data  <= FIELD_W'(value);
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    node_cfg = value;
  endtask

  // Random graphs: mostly well-formed edges between live nodes with small
  // capacities, so that ties between cuts are common, plus some out-of-range
  // nodes, large capacities and cut reads mixed in.
  task automatic random_graph();
    int unsigned n_edges, nn, tail, head, cap;
    n_edges = $urandom_range(1, 8);
    nn = live_nodes();
    for (int unsigned e = 0; e < n_edges; e++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(read_beat($urandom_range(0, 6)));
        random_sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        tail = $urandom_range(0, 63);
        head = $urandom_range(0, 63);
      end else begin
        tail = $urandom_range(1, nn);
        head = $urandom_range(1, nn);
        if ($urandom_range(0, 2) == 0) tail = 1;
        if ($urandom_range(0, 2) == 0) head = nn;
      end
      case ($urandom_range(0, 5))
        0:       cap = $urandom_range(0, 16777215);
        1:       cap = 16777215;
        default: cap = $urandom_range(0, 7);
      endcase
      send_beat(edge_beat(tail, head, cap, e == n_edges - 1));
      random_sent++;
    end
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 7) == 0)
        send_beat(read_beat($urandom_range(0, 1023)));
      else
        send_beat(read_beat($urandom_range(0, 8)));
      random_sent++;
    end
  endtask

  // Result side: a fresh idle draw before each beat, and one long hold-off when asked.
  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_if.ready <= 1'b0;
        hold_out = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reads before any solve must report an empty cut and an invalid position.
    send_beat(read_beat(0));
    send_beat(read_beat(1023));

    // Default of 32 nodes: a real path through node 16, a direct edge, a self loop,
    // and edges touching node 0 or nodes beyond the count, which carry nothing.
    send_beat(edge_beat(1, 32, 16777215, 1'b0));
    send_beat(edge_beat(1, 16, 0, 1'b0));
    send_beat(edge_beat(16, 32, 5, 1'b0));
    send_beat(edge_beat(5, 5, 7, 1'b0));
    send_beat(edge_beat(0, 32, 9, 1'b0));
    send_beat(edge_beat(1, 40, 9, 1'b0));
    send_beat(edge_beat(63, 63, 1, 1'b1));
    send_beat(read_beat(0));
    send_beat(read_beat(1));
    send_beat(read_beat(2));
    send_beat(read_beat(1023));

    // A count of zero behaves as two nodes; parallel edges include a zero capacity.
    write_node_count(0);
    send_beat(edge_beat(1, 2, 0, 1'b0));
    send_beat(edge_beat(2, 1, 3, 1'b0));
    send_beat(edge_beat(1, 2, 16777215, 1'b1));
    send_beat(read_beat(0));
    send_beat(read_beat(1));

    // Counts above the maximum clamp to 32 nodes.
    write_node_count(63);
    send_beat(edge_beat(1, 32, 100, 1'b1));
    send_beat(read_beat(0));

    // A count of one acts as two; a lone self loop leaves the cut empty.
    write_node_count(1);
    send_beat(edge_beat(2, 2, 5, 1'b1));
    send_beat(read_beat(0));

    // Pressure: results are held back for a long stretch while reads keep coming,
    // so the output side fills and the input has to stall.
    write_node_count(4);
    send_beat(edge_beat(1, 2, 3, 1'b0));
    send_beat(edge_beat(2, 4, 3, 1'b0));
    send_beat(edge_beat(1, 4, 2, 1'b1));
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    flat_out = 1'b1;
    hold_out = 1'b1;
    for (int k = 0; k < 40; k++) send_beat(read_beat(k % 4));
    flat_out = 1'b0;

    // Random graphs, with the node count rewritten every few graphs.
    for (int g = 0; random_sent < RANDOM_ITEMS; g++) begin
      if (g % 8 == 0) begin
        case ($urandom_range(0, 5))
          0:       write_node_count(32);
          1:       write_node_count($urandom_range(0, 63));
          default: write_node_count($urandom_range(2, 8));
        endcase
      end
      flat_out = ($urandom_range(0, 3) == 0);
      random_graph();
    end
    flat_out = 1'b0;

    // Full edge store: 1025 parallel edges of full capacity between the two nodes,
    // so the last one is dropped while its flag still starts the solve. Every kept
    // edge lands in the cut and the cut capacity reaches its largest value.
    write_node_count(2);
    flat_out = 1'b1;
    for (int e = 0; e <= MAX_EDGES; e++)
      send_beat(edge_beat(1, 2, 16777215, e == MAX_EDGES));
    send_beat(read_beat(0));
    send_beat(read_beat(512));
    send_beat(read_beat(1023));
    flat_out = 1'b0;

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
